// ----- rtl/tmes_pkg.sv -----
`timescale 1ns / 1ps
package tmes_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
	localparam logic [3:0] MIDI_NOTE_ON = 4'h9;
	localparam logic [3:0] MIDI_CONTROLLER = 4'hB;
	localparam logic [3:0] MIDI_PROGRAM = 4'hC;
	localparam logic [3:0] MIDI_PITCH_WHEEL = 4'hE;

	localparam logic [2:0] ACT_NOTE_OFF = 3'd0;
	localparam logic [2:0] ACT_NOTE_ON = 3'd1;
	localparam logic [2:0] ACT_CONTROLLER = 3'd2;
	localparam logic [2:0] ACT_PROGRAM = 3'd3;
	localparam logic [2:0] ACT_PITCH_WHEEL = 3'd4;
	localparam logic [2:0] ACT_IGNORED = 3'd5;
	localparam logic [2:0] ACT_DROPPED = 3'd6;

	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_SHIFT = 2'd2;
	localparam logic [1:0] CELL_SUB = 2'd3;

	typedef struct packed {
		logic [15:0] offset;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
	} entry_t;

	typedef struct packed {
		logic advance;
		logic [15:0] value;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		entry_t ins;
		logic [15:0] n;
	} cell_ctl_t;

	function automatic logic [2:0] decode_action(input logic [7:0] status, input logic [6:0] d2);
		logic [2:0] act;
		case (status[7:4])
			MIDI_NOTE_OFF: act = ACT_NOTE_OFF;
			MIDI_NOTE_ON: act = (d2 == 7'd0) ? ACT_NOTE_OFF : ACT_NOTE_ON;
			MIDI_CONTROLLER: act = ACT_CONTROLLER;
			MIDI_PROGRAM: act = ACT_PROGRAM;
			MIDI_PITCH_WHEEL: act = ACT_PITCH_WHEEL;
			default: act = ACT_IGNORED;
		endcase
		return act;
	endfunction

endpackage

// ----- rtl/timestamped_midi_event_scheduler.sv -----
`timescale 1ns / 1ps
// With the back end idle, a schedule word taken from the command FIFO is inserted into the sorted
// event array, or its dropped result is registered, as the back end takes it; one word per cycle
// unless a dropped result waits on a stalled output. An advance word of nonzero length drains the
// due events, one per cycle while the output accepts them, set by the single head read of the
// event array, then a final offset update pass subtracts the length from the remaining offsets.
// Reset is asynchronous and active low; it empties the event array, command queue and output.
module timestamped_midi_event_scheduler import tmes_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [15:0] sample_offset,
	input logic [7:0] status_byte,
	input logic [6:0] first_data,
	input logic [6:0] second_data,
	input logic [15:0] block_length,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] position,
	output logic [3:0] channel,
	output logic [2:0] action,
	output logic [6:0] out_first,
	output logic [6:0] out_second,
	output logic last
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	tmes_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.sample_offset(sample_offset),
		.status_byte(status_byte),
		.first_data(first_data),
		.second_data(second_data),
		.block_length(block_length),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	tmes_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.channel(channel),
		.action(action),
		.out_first(out_first),
		.out_second(out_second),
		.last(last)
	);

endmodule

// ----- rtl/tmes_front.sv -----
`timescale 1ns / 1ps
module tmes_front import tmes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [15:0] sample_offset,
	input logic [7:0] status_byte,
	input logic [6:0] first_data,
	input logic [6:0] second_data,
	input logic [15:0] block_length,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);

	cmd_t fifo_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	cmd_t in_cmd;
	logic push;
	logic pop;

	always_comb begin
		in_cmd.advance = kind;
		in_cmd.value = kind ? block_length : sample_offset;
		in_cmd.status = status_byte;
		in_cmd.d1 = first_data;
		in_cmd.d2 = second_data;
	end

	assign in_ready = (cnt_q != CMD_CNT_W'(CMD_FIFO_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = fifo_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tmes_cells.sv -----
`timescale 1ns / 1ps
module tmes_cells import tmes_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input cell_ctl_t ctl,
	output entry_t head,
	output logic [15:0] second_offset,
	output logic [CW-1:0] count
);

	entry_t q_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;
	logic [QUEUE_DEPTH-1:0] after;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			after[i] = !((CW'(i) < count_q) && (q_q[i].offset <= ctl.ins.offset));
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		entry_t from_left;
		entry_t from_right;
		logic take_new;

		if (g == 0) begin : g_first
			assign from_left = ctl.ins;
			assign take_new = 1'b1;
		end else begin : g_mid
			assign from_left = q_q[g-1];
			assign take_new = !after[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign from_right = q_q[g];
		end else begin : g_inner
			assign from_right = q_q[g+1];
		end

		always_ff @(posedge clk) begin
			case (ctl.op)
				CELL_INSERT: begin
					if (after[g]) begin
						q_q[g] <= take_new ? ctl.ins : from_left;
					end
				end
				CELL_SHIFT: q_q[g] <= from_right;
				CELL_SUB: q_q[g].offset <= q_q[g].offset - ctl.n;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctl.op)
				CELL_INSERT: count_q <= count_q + 1'b1;
				CELL_SHIFT: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign head = q_q[0];
	assign second_offset = q_q[1].offset;
	assign count = count_q;

endmodule

// ----- rtl/tmes_back.sv -----
`timescale 1ns / 1ps
module tmes_back import tmes_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] position,
	output logic [3:0] channel,
	output logic [2:0] action,
	output logic [6:0] out_first,
	output logic [6:0] out_second,
	output logic last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_SUB = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [15:0] n_q;
	logic out_valid_q;
	logic out_free;
	logic load;
	entry_t load_entry;
	logic [2:0] load_action;
	logic load_last;
	cell_ctl_t ctl;
	entry_t head;
	logic [15:0] second_offset;
	logic [CW-1:0] count;
	logic full;
	logic head_due;
	logic head_last;
	entry_t cmd_entry;

	tmes_cells #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cells (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.head(head),
		.second_offset(second_offset),
		.count(count)
	);

	assign out_free = !out_valid_q || out_ready;
	assign full = (count == CW'(QUEUE_DEPTH));
	assign head_due = (count != '0) && (head.offset < n_q);
	assign head_last = (count == CW'(1)) || !(second_offset < n_q);

	always_comb begin
		cmd_entry.offset = cmd.value;
		cmd_entry.status = cmd.status;
		cmd_entry.d1 = cmd.d1;
		cmd_entry.d2 = cmd.d2;
	end

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		load = 1'b0;
		load_entry = cmd_entry;
		load_action = ACT_DROPPED;
		load_last = 1'b1;
		ctl.op = CELL_HOLD;
		ctl.ins = cmd_entry;
		ctl.n = n_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.advance) begin
						if (full) begin
							if (out_free) begin
								load = 1'b1;
								cmd_ready = 1'b1;
							end
						end else begin
							ctl.op = CELL_INSERT;
							cmd_ready = 1'b1;
						end
					end else begin
						cmd_ready = 1'b1;
						if (cmd.value != 16'd0) begin
							state_d = ST_DRAIN;
						end
					end
				end
			end
			ST_DRAIN: begin
				load_entry = head;
				load_action = decode_action(head.status, head.d2);
				load_last = head_last;
				if (!head_due) begin
					state_d = ST_SUB;
				end else if (out_free) begin
					load = 1'b1;
					ctl.op = CELL_SHIFT;
					if (head_last) begin
						state_d = ST_SUB;
					end
				end
			end
			ST_SUB: begin
				ctl.op = CELL_SUB;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd.advance) begin
			n_q <= cmd.value;
		end
		if (load) begin
			position <= load_entry.offset;
			channel <= load_entry.status[3:0];
			action <= load_action;
			out_first <= load_entry.d1;
			out_second <= load_entry.d2;
			last <= load_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- verif/timestamped_midi_event_scheduler_tb.sv -----
`timescale 1ns / 1ps
module timestamped_midi_event_scheduler_tb;
	import tmes_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_ITEMS = 330;

	typedef struct packed {
		logic [15:0] position;
		logic [3:0] channel;
		logic [2:0] action;
		logic [6:0] first_byte;
		logic [6:0] second_byte;
		logic last;
	} midi_result_t;

	class midi_scoreboard;
		entry_t slots [DEPTH];
		int unsigned fill;
		midi_result_t expected_q [$];
		int unsigned errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function logic [2:0] action_of(logic [7:0] st, logic [6:0] d2);
			case (st[7:4])
				MIDI_NOTE_OFF: return ACT_NOTE_OFF;
				MIDI_NOTE_ON: return (d2 == 7'd0) ? ACT_NOTE_OFF : ACT_NOTE_ON;
				MIDI_CONTROLLER: return ACT_CONTROLLER;
				MIDI_PROGRAM: return ACT_PROGRAM;
				MIDI_PITCH_WHEEL: return ACT_PITCH_WHEEL;
				default: return ACT_IGNORED;
			endcase
		endfunction

		function void note_word(logic k, logic [15:0] off, logic [7:0] st, logic [6:0] d1,
				logic [6:0] d2, logic [15:0] n);
			midi_result_t r;
			int unsigned idx;
			int unsigned emit;
			if (k == 1'b0) begin
				if (fill >= DEPTH) begin
					r.position = off;
					r.channel = st[3:0];
					r.action = ACT_DROPPED;
					r.first_byte = d1;
					r.second_byte = d2;
					r.last = 1'b1;
					expected_q = {expected_q, r};
					return;
				end
				idx = 0;
				while (idx < fill && slots[idx].offset <= off)
					idx++;
				for (int i = fill; i > idx; i--)
					slots[i] = slots[i - 1];
				slots[idx].offset = off;
				slots[idx].status = st;
				slots[idx].d1 = d1;
				slots[idx].d2 = d2;
				fill++;
			end else begin
				if (n == 16'd0)
					return;
				emit = 0;
				while (emit < fill && slots[emit].offset < n)
					emit++;
				for (int i = 0; i < emit; i++) begin
					r.position = slots[i].offset;
					r.channel = slots[i].status[3:0];
					r.action = action_of(slots[i].status, slots[i].d2);
					r.first_byte = slots[i].d1;
					r.second_byte = slots[i].d2;
					r.last = (i + 1 == emit);
					expected_q = {expected_q, r};
				end
				for (int i = emit; i < fill; i++) begin
					slots[i - emit] = slots[i];
					slots[i - emit].offset = slots[i].offset - n;
				end
				fill = fill - emit;
			end
		endfunction

		function void compare_field(string fname, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v,
					act_v);
			end
		endfunction

		function void check_word(midi_result_t got);
			midi_result_t exp_r;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				return;
			end
			exp_r = expected_q[0];
			expected_q.delete(0);
			compare_field("position", exp_r.position, got.position);
			compare_field("channel", exp_r.channel, got.channel);
			compare_field("action", exp_r.action, got.action);
			compare_field("out_first", exp_r.first_byte, got.first_byte);
			compare_field("out_second", exp_r.second_byte, got.second_byte);
			compare_field("last", exp_r.last, got.last);
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [15:0] sample_offset;
	logic [7:0] status_byte;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [15:0] block_length;
	logic out_valid;
	logic out_ready;
	logic [15:0] position;
	logic [3:0] channel;
	logic [2:0] action;
	logic [6:0] out_first;
	logic [6:0] out_second;
	logic last;

	midi_scoreboard sb;
	bit hold_req;
	int unsigned burst_left;
	int unsigned items_sent;
	int unsigned cycle_count;

	timestamped_midi_event_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.sample_offset(sample_offset),
		.status_byte(status_byte),
		.first_data(first_data),
		.second_data(second_data),
		.block_length(block_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.channel(channel),
		.action(action),
		.out_first(out_first),
		.out_second(out_second),
		.last(last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[timestamped_midi_event_scheduler] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word('{position, channel, action, out_first, out_second, last});
	end

	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned phase;
		logic [15:0] pattern;
		out_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		phase = 0;
		pattern = '1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 80);
				pattern = 16'($urandom());
			end
			mode_left--;
			phase++;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = pattern[phase % 16];
				default: out_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic put_word(logic k, logic [15:0] off, logic [7:0] st, logic [6:0] d1,
			logic [6:0] d2, logic [15:0] n);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid = 1'b1;
		kind = k;
		sample_offset = off;
		status_byte = st;
		first_data = d1;
		second_data = d2;
		block_length = n;
		do @(posedge clk); while (!in_ready);
		sb.note_word(k, off, st, d1, d2, n);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic schedule_word(logic [15:0] off, logic [7:0] st, logic [6:0] d1,
			logic [6:0] d2);
		put_word(1'b0, off, st, d1, d2, 16'($urandom()));
	endtask

	task automatic advance_word(logic [15:0] n);
		put_word(1'b1, 16'($urandom()), 8'($urandom()), 7'($urandom()), 7'($urandom()), n);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_status();
		logic [3:0] cmd_nib;
		case ($urandom_range(0, 9))
			0, 1: cmd_nib = MIDI_NOTE_ON;
			2: cmd_nib = MIDI_NOTE_OFF;
			3: cmd_nib = MIDI_CONTROLLER;
			4: cmd_nib = MIDI_PROGRAM;
			5: cmd_nib = MIDI_PITCH_WHEEL;
			default: cmd_nib = 4'($urandom());
		endcase
		return {cmd_nib, 4'($urandom())};
	endfunction

	task automatic fill_and_flush();
		int unsigned extra;
		extra = (DEPTH - sb.fill) + $urandom_range(1, 4);
		repeat (extra)
			schedule_word(16'($urandom_range(0, 2000)), pick_status(), 7'($urandom()),
				7'($urandom()));
		advance_word(16'($urandom_range(0, 1000)));
		repeat ($urandom_range(0, 3))
			schedule_word(16'($urandom()), pick_status(), 7'($urandom()), 7'($urandom()));
		advance_word(16'hFFFF);
	endtask

	initial begin
		int unsigned window;
		int unsigned nsched;
		logic [15:0] prev_off;
		logic [15:0] off;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		sample_offset = '0;
		status_byte = '0;
		first_data = '0;
		second_data = '0;
		block_length = '0;
		hold_req = 1'b0;
		burst_left = 0;
		items_sent = 0;
		cycle_count = 0;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		advance_word(16'd10);
		advance_word(16'd0);
		schedule_word(16'd5, {MIDI_NOTE_ON, 4'h0}, 7'd60, 7'd100);
		schedule_word(16'd5, {MIDI_NOTE_ON, 4'hF}, 7'd61, 7'd0);
		schedule_word(16'd0, {MIDI_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
		schedule_word(16'd3, {MIDI_CONTROLLER, 4'h3}, 7'd127, 7'd127);
		schedule_word(16'd7, {MIDI_PROGRAM, 4'h5}, 7'd10, 7'd0);
		schedule_word(16'd9, {MIDI_PITCH_WHEEL, 4'h7}, 7'd0, 7'd127);
		schedule_word(16'd2, 8'h00, 7'd85, 7'd42);
		schedule_word(16'd4, 8'hFF, 7'd42, 7'd85);
		schedule_word(16'hFFFF, 8'hA1, 7'd1, 7'd2);
		schedule_word(16'd6, 8'hD2, 7'd3, 7'd4);
		advance_word(16'd0);
		advance_word(16'd5);
		advance_word(16'd1);
		advance_word(16'hFFFF);
		advance_word(16'hFFFF);
		wait_drained();

		hold_req = 1'b1;
		fill_and_flush();
		wait_drained();

		while (items_sent < TARGET_ITEMS) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3, 4, 5: begin
					case ($urandom_range(0, 2))
						0: window = 16;
						1: window = 256;
						default: window = 4096;
					endcase
					nsched = $urandom_range(1, 10);
					prev_off = 16'($urandom_range(0, window));
					repeat (nsched) begin
						off = ($urandom_range(0, 3) == 0) ? prev_off
							: 16'($urandom_range(0, window));
						schedule_word(off, pick_status(), 7'($urandom()),
							($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom()));
						prev_off = off;
					end
					repeat ($urandom_range(1, 3))
						advance_word(($urandom_range(0, 7) == 0) ? 16'd0
							: 16'($urandom_range(0, window)));
				end
				6, 7: fill_and_flush();
				8, 9: begin
					repeat ($urandom_range(1, 4))
						put_word(1'($urandom()), 16'($urandom()), 8'($urandom()),
							7'($urandom()), 7'($urandom()), 16'($urandom()));
				end
				10: begin
					advance_word(16'd0);
					schedule_word(16'($urandom()), pick_status(), 7'($urandom()),
						7'($urandom()));
					advance_word(16'($urandom_range(1, 8)));
					advance_word(16'hFFFF);
					advance_word(16'($urandom()));
				end
				default: wait_drained();
			endcase
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("[timestamped_midi_event_scheduler] OK");
		end else begin
			$display("[timestamped_midi_event_scheduler] ERROR");
		end
		$finish;
	end

endmodule
